/* rtl/core/apt_pkg.sv */
package apt_pkg;

  localparam int unsigned CAP_W    = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned OVF_W    = 8;
  localparam int unsigned FACTOR_W = 24;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // numerator is the RPM scale factor shifted left by up to 4 bits (log2 of the edge count)
  localparam int unsigned NUM_W = FACTOR_W + 4;
  // shared adder width: ppr (up to 6) times a 32-bit period, plus one shift bit
  localparam int unsigned ALU_W = PERIOD_W + 4;

  localparam logic [FACTOR_W-1:0] RPM_SCALE_RST      = 24'd7500000;
  localparam logic [THRESH_W-1:0] FAST_THRESHOLD_RST = 16'd9000;
  localparam logic [THRESH_W-1:0] SLOW_THRESHOLD_RST = 16'd36000;

  localparam logic [SEL_W-1:0] SEL_LAST = 3'd4;

  typedef enum logic [1:0] {
    FUNC_CAPTURE  = 2'd0,
    FUNC_OVERFLOW = 2'd1,
    FUNC_REFRESH  = 2'd2,
    FUNC_BUTTON   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_SCALE      = 2'd0,
    CFG_FAST_THRESHOLD = 2'd1,
    CFG_SLOW_THRESHOLD = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  localparam logic [MODE_W-1:0] MODE_ONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FOUR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIXTEEN = 2'd2;

  // log2 of the edge count per capture
  function automatic logic [2:0] mode_shift(input logic [MODE_W-1:0] mode);
    logic [2:0] sh;
    case (mode)
      MODE_FOUR:    sh = 3'd2;
      MODE_SIXTEEN: sh = 3'd4;
      default:      sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

/* rtl/core/apt_if.sv */
interface apt_in_if;
  logic                           valid;
  logic                           ready;
  apt_pkg::func_t                 func;
  logic [apt_pkg::CAP_W-1:0]      capture_value;
  logic                           button_level;

  modport source (output valid, func, capture_value, button_level, input ready);
  modport sink   (input valid, func, capture_value, button_level, output ready);
endinterface

interface apt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           display_update;
  logic [apt_pkg::VALUE_W-1:0]    display_value;
  logic [apt_pkg::MODE_W-1:0]     prescale_code;
  logic [apt_pkg::SEL_W-1:0]      selection;
  logic                           save_request;

  modport source (output valid, display_update, display_value, prescale_code, selection,
                  save_request, input ready);
  modport sink   (input valid, display_update, display_value, prescale_code, selection,
                  save_request, output ready);
endinterface

interface apt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [apt_pkg::CFG_IDX_W-1:0]     index;
  logic [apt_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/autorange_period_tachometer_unit.sv */
// Autoranging period tachometer.
// in_ch carries one event per transaction: a timer capture, a timer overflow,
// a display refresh tick or a button sample. Every event gives exactly one
// transaction on out_ch with the current reading, prescale code and selection.
// cfg_ch writes the RPM scale factor (0), fast_threshold (1) and slow_threshold
// (2); it is always ready and should only be used while no event is in flight.
// Path per event: overflow, button, start capture and non-computing refresh
// events go straight to the output hand-off; a refresh whose divisor is zero
// passes through the divisor step first; a stop capture builds the period and
// does two range compares on the shared adder; a refresh that computes RPM
// runs the 28-step restoring divider on that adder. in_ch.ready returns in the
// cycle after the result is loaded.
// One event is processed at a time; in_ch.ready is high only when idle.
// A finished result waits in the output register while out_ch.ready is low;
// a new event can be accepted meanwhile, and it stalls only at its own
// hand-off until the register drains.
// Reset (synchronous, rst_n low) clears selection, output valid and all
// measurement state but the datapath registers, and loads the register defaults.
module autorange_period_tachometer_unit #(
  parameter int unsigned TIMEOUT_OVERFLOWS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  apt_in_if.sink       in_ch,
  apt_out_if.source    out_ch,
  apt_cfg_if.sink      cfg_ch
);

  localparam int unsigned ALU_W = apt_pkg::ALU_W;
  localparam int unsigned NUM_W = apt_pkg::NUM_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DIFF = 10'b00_0000_0010,
    S_OVFH = 10'b00_0000_0100,
    S_OVFL = 10'b00_0000_1000,
    S_CMPF = 10'b00_0001_0000,
    S_CMPS = 10'b00_0010_0000,
    S_DEN  = 10'b00_0100_0000,
    S_DIV  = 10'b00_1000_0000,
    S_SAT  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [apt_pkg::FACTOR_W-1:0] freq_r;
  logic [apt_pkg::THRESH_W-1:0] fast_r;
  logic [apt_pkg::THRESH_W-1:0] slow_r;

  logic                         armed_r, armed_nxt;
  logic [apt_pkg::CAP_W-1:0]    start_r, start_nxt;
  logic [apt_pkg::CAP_W-1:0]    cap_r, cap_nxt;
  logic [apt_pkg::OVF_W-1:0]    ovf_r, ovf_nxt;
  logic [apt_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [apt_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic                         ready_r, ready_nxt;
  logic [apt_pkg::SEL_W-1:0]    sel_r, sel_nxt;
  logic                         btn_last_r, btn_last_nxt;
  logic [apt_pkg::VALUE_W-1:0]  shown_r, shown_nxt;
  logic                         upd_r, upd_nxt;
  logic                         save_r, save_nxt;
  logic                         lt_fast_r, lt_fast_nxt;

  logic [ALU_W-1:0]             acc_r, acc_nxt;    // period build, then divider remainder
  logic [ALU_W-1:0]             den_r, den_nxt;
  logic [NUM_W-1:0]             num_r, num_nxt;    // dividend shifting out, quotient in
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_update_r;
  logic [apt_pkg::VALUE_W-1:0]  out_value_r;
  logic [apt_pkg::MODE_W-1:0]   out_mode_r;
  logic [apt_pkg::SEL_W-1:0]    out_sel_r;
  logic                         out_save_r;
  logic                         out_load;

  // shared adder / subtractor
  logic [ALU_W-1:0]             alu_a, alu_b;
  logic                         alu_sub;
  logic [ALU_W:0]               alu_sum;
  logic                         alu_borrow;

  logic [ALU_W-1:0]             per_edge;
  logic [ALU_W-1:0]             p1, p2, p4;
  logic [ALU_W-1:0]             rem_shift;
  logic                         in_fire;
  logic [apt_pkg::MODE_W-1:0]   mode_pick;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign per_edge  = ALU_W'(period_r >> apt_pkg::mode_shift(mode_r));
  assign p1        = ALU_W'(period_r);
  assign p2        = p1 << 1;
  assign p4        = p1 << 2;
  assign rem_shift = {acc_r[ALU_W-2:0], num_r[NUM_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_DIFF: begin
        alu_a   = ALU_W'(cap_r);
        alu_b   = ALU_W'(start_r);
        alu_sub = 1'b1;
      end
      S_OVFH: begin
        alu_a = acc_r;
        alu_b = ALU_W'({ovf_r, 16'h0000});
      end
      S_OVFL: begin
        alu_a   = acc_r;
        alu_b   = ALU_W'(ovf_r);
        alu_sub = 1'b1;
      end
      S_CMPF: begin
        alu_a   = per_edge;
        alu_b   = ALU_W'(fast_r);
        alu_sub = 1'b1;
      end
      S_CMPS: begin
        alu_a   = per_edge;
        alu_b   = ALU_W'(slow_r);
        alu_sub = 1'b1;
      end
      S_DEN: begin
        // pulses per rev 3,4,5,6,1 as shift-and-add of the period
        case (sel_r)
          3'd0:    begin alu_a = p2; alu_b = p1; end
          3'd1:    begin alu_a = p4; alu_b = '0; end
          3'd2:    begin alu_a = p4; alu_b = p1; end
          3'd3:    begin alu_a = p4; alu_b = p2; end
          default: begin alu_a = p1; alu_b = '0; end
        endcase
      end
      S_DIV: begin
        alu_a   = rem_shift;
        alu_b   = den_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_sum[ALU_W];

  assign mode_pick = lt_fast_r  ? apt_pkg::MODE_SIXTEEN :
                     alu_borrow ? apt_pkg::MODE_FOUR    : apt_pkg::MODE_ONE;

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    armed_nxt    = armed_r;
    start_nxt    = start_r;
    cap_nxt      = cap_r;
    ovf_nxt      = ovf_r;
    period_nxt   = period_r;
    mode_nxt     = mode_r;
    ready_nxt    = ready_r;
    sel_nxt      = sel_r;
    btn_last_nxt = btn_last_r;
    shown_nxt    = shown_r;
    upd_nxt      = upd_r;
    save_nxt     = save_r;
    lt_fast_nxt  = lt_fast_r;
    acc_nxt      = acc_r;
    den_nxt      = den_r;
    num_nxt      = num_r;
    cnt_nxt      = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          upd_nxt   = 1'b0;
          save_nxt  = 1'b0;
          state_nxt = S_EMIT;
          case (in_ch.func)
            apt_pkg::FUNC_CAPTURE: begin
              ovf_nxt = '0;
              if (!armed_r) begin
                start_nxt = in_ch.capture_value;
                armed_nxt = 1'b1;
              end else begin
                // stop capture: overflow count is still needed, cleared in S_OVFL
                ovf_nxt   = ovf_r;
                cap_nxt   = in_ch.capture_value;
                armed_nxt = 1'b0;
                state_nxt = S_DIFF;
              end
            end
            apt_pkg::FUNC_OVERFLOW: begin
              if (ovf_r != '1) ovf_nxt = ovf_r + 1'b1;
            end
            apt_pkg::FUNC_REFRESH: begin
              if (ovf_r >= apt_pkg::OVF_W'(TIMEOUT_OVERFLOWS)) begin
                period_nxt = '0;
                shown_nxt  = '0;
                upd_nxt    = 1'b1;
              end else if (ready_r) begin
                state_nxt = S_DEN;
              end
            end
            default: begin
              if (!in_ch.button_level && btn_last_r) begin
                btn_last_nxt = 1'b0;
                sel_nxt      = (sel_r >= apt_pkg::SEL_LAST) ? '0 : sel_r + 1'b1;
                save_nxt     = 1'b1;
              end else begin
                btn_last_nxt = in_ch.button_level;
              end
            end
          endcase
        end
      end
      S_DIFF: begin
        acc_nxt   = alu_sum[ALU_W-1:0];
        state_nxt = S_OVFH;
      end
      S_OVFH: begin
        acc_nxt   = alu_sum[ALU_W-1:0];
        state_nxt = S_OVFL;
      end
      S_OVFL: begin
        period_nxt = alu_sum[apt_pkg::PERIOD_W-1:0];
        ovf_nxt    = '0;
        state_nxt  = S_CMPF;
      end
      S_CMPF: begin
        lt_fast_nxt = alu_borrow;
        state_nxt   = S_CMPS;
      end
      S_CMPS: begin
        mode_nxt  = mode_pick;
        ready_nxt = (mode_pick == mode_r);
        state_nxt = S_EMIT;
      end
      S_DEN: begin
        den_nxt = alu_sum[ALU_W-1:0];
        acc_nxt = '0;
        num_nxt = NUM_W'({freq_r, 4'h0} >> (3'd4 - apt_pkg::mode_shift(mode_r)));
        cnt_nxt = '0;
        upd_nxt = 1'b1;
        if (alu_sum[ALU_W-1:0] == '0) begin
          shown_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt = alu_borrow ? rem_shift : alu_sum[ALU_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], !alu_borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = S_SAT;
      end
      S_SAT: begin
        shown_nxt = (|num_r[NUM_W-1:apt_pkg::VALUE_W]) ? '1
                                                        : num_r[apt_pkg::VALUE_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      freq_r      <= apt_pkg::RPM_SCALE_RST;
      fast_r      <= apt_pkg::FAST_THRESHOLD_RST;
      slow_r      <= apt_pkg::SLOW_THRESHOLD_RST;
      armed_r     <= 1'b0;
      start_r     <= '0;
      ovf_r       <= '0;
      period_r    <= '0;
      mode_r      <= apt_pkg::MODE_ONE;
      ready_r     <= 1'b0;
      sel_r       <= '0;
      btn_last_r  <= 1'b0;
      shown_r     <= '0;
      upd_r       <= 1'b0;
      save_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      start_r     <= start_nxt;
      ovf_r       <= ovf_nxt;
      period_r    <= period_nxt;
      mode_r      <= mode_nxt;
      ready_r     <= ready_nxt;
      sel_r       <= sel_nxt;
      btn_last_r  <= btn_last_nxt;
      shown_r     <= shown_nxt;
      upd_r       <= upd_nxt;
      save_r      <= save_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (apt_pkg::cfg_idx_t'(cfg_ch.index))
          apt_pkg::CFG_RPM_SCALE:      freq_r <= cfg_ch.data;
          apt_pkg::CFG_FAST_THRESHOLD: fast_r <= cfg_ch.data[apt_pkg::THRESH_W-1:0];
          apt_pkg::CFG_SLOW_THRESHOLD: slow_r <= cfg_ch.data[apt_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    cap_r     <= cap_nxt;
    acc_r     <= acc_nxt;
    den_r     <= den_nxt;
    num_r     <= num_nxt;
    lt_fast_r <= lt_fast_nxt;
    if (out_load) begin
      out_update_r <= upd_r;
      out_value_r  <= shown_r;
      out_mode_r   <= mode_r;
      out_sel_r    <= sel_r;
      out_save_r   <= save_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.display_update = out_update_r;
  assign out_ch.display_value  = out_value_r;
  assign out_ch.prescale_code  = out_mode_r;
  assign out_ch.selection      = out_sel_r;
  assign out_ch.save_request   = out_save_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken again while an event is in flight");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_W'(NUM_W - 1)))
    else $error("divider step count overran");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 2'd3)
    else $error("prescale code 3 reached");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= apt_pkg::SEL_LAST)
    else $error("selection out of table range");

  a_update_xor_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_update_r && out_save_r))
    else $error("display update and save request in one transaction");

endmodule
